// ===== hw/rtl/byte_vm_execute_unit_assert.svh =====
// Assertion macros for the byte VM execute unit.
// Included by files that check their own logic; expects signals named clock and reset.
`ifndef BYTE_VM_EXECUTE_UNIT_ASSERT_SVH
`define BYTE_VM_EXECUTE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BVM_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BVM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/bvm_pkg.sv =====
// Shared types and codes for the byte VM execute unit.
// No dependencies; compiled first.
package bvm_pkg;

   // Opcodes
   localparam logic [7:0] OP_HALT  = 8'h00;
   localparam logic [7:0] OP_LOAD  = 8'h10;
   localparam logic [7:0] OP_STORE = 8'h20;
   localparam logic [7:0] OP_MOVE  = 8'h30;
   localparam logic [7:0] OP_LDI   = 8'h40;
   localparam logic [7:0] OP_ADD   = 8'h50;
   localparam logic [7:0] OP_SUB   = 8'h60;
   localparam logic [7:0] OP_GT    = 8'h70;
   localparam logic [7:0] OP_GE    = 8'h80;
   localparam logic [7:0] OP_EQ    = 8'h90;
   localparam logic [7:0] OP_ITE   = 8'ha0;
   localparam logic [7:0] OP_JUMP  = 8'hb0;

   // Result status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_HALT    = 2'd1;
   localparam logic [1:0] STAT_ADDR    = 2'd2;
   localparam logic [1:0] STAT_ILLEGAL = 2'd3;

   // Instruction beat
   typedef struct packed {
      logic [7:0] cmd;
      logic [7:0] op_a;
      logic [7:0] op_b;
      logic [7:0] op_c;
   } req_payload_type;

   // Result beat
   typedef struct packed {
      logic [1:0] status;
      logic       redirect;
      logic [7:0] redirect_target;
   } rsp_payload_type;

   // Top-level mode: memory clearing pass, then normal operation
   typedef enum logic {
      MODE_CLEAR,
      MODE_RUN
   } mode_type;

endpackage

// ===== hw/rtl/bvm_stream_if.sv =====
// Valid/ready stream interface used for the instruction and result channels.
// Payload type is set by the instantiating scope; no package dependency.
interface bvm_stream_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ===== hw/rtl/bvm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependency; used for the register file copies and the data memory.
module bvm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; a same-edge read returns old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/byte_vm_execute_unit.sv =====
// Byte VM execute unit: top level, two-stage execute/writeback around synchronous RAMs.
// Depends on bvm_pkg, bvm_stream_if, bvm_ram and byte_vm_execute_unit_assert.svh.

// A new instruction beat is not taken while the execute stage holds one. The register file is
// a synchronous RAM with registered read data: operands are read on the accept edge, the
// execute stage computes in the next cycle, and writeback follows in the cycle after; a write
// landing on the same edge as the next read is forwarded. Loads read the byte memory in
// execute and write the register file in writeback. A result beat enters a two-entry output
// queue from the writeback stage and can wait there; a new beat is taken only while the queue
// has room reserved for its result. After reset the unit clears its data memory (and the
// register file alongside it) at one entry per cycle, all MEM_BYTES entries (8192 at the
// default), and takes no instruction until done.
// Register indexes at or above REG_COUNT read as zero and are not written.

`include "byte_vm_execute_unit_assert.svh"

module byte_vm_execute_unit
   import bvm_pkg::*;
#(
   parameter int REG_COUNT = 256,
   parameter int MEM_BYTES = 8192
) (
   input  logic         clock,
   input  logic         reset,
   bvm_stream_if.sink   req_bus,
   bvm_stream_if.source rsp_bus
);

   localparam int RW = $clog2(REG_COUNT);
   localparam int MW = $clog2(MEM_BYTES);
   localparam logic [8:0]    REG_LIMIT     = 9'(REG_COUNT);
   localparam logic [31:0]   MEM_LIMIT     = 32'(MEM_BYTES);
   localparam logic [MW-1:0] CLR_LAST      = MW'(MEM_BYTES - 1);
   localparam logic [MW:0]   CLR_REG_LIMIT = (MW + 1)'(REG_COUNT);

   // Port A reads the address/condition register for store and ite, else op_b
   function automatic logic [7:0] src1_index(input req_payload_type r);
      if (r.cmd == OP_STORE || r.cmd == OP_ITE) begin
         return r.op_a;
      end
      return r.op_b;
   endfunction

   // Port B reads the store data register for store, else op_c
   function automatic logic [7:0] src2_index(input req_payload_type r);
      if (r.cmd == OP_STORE) begin
         return r.op_b;
      end
      return r.op_c;
   endfunction

   // ---------------------------------------------------------------
   // Declarations
   // ---------------------------------------------------------------
   mode_type        mode_ff, mode_in;
   logic [MW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic            clearing;

   logic            req_fire;
   logic            fifo_room;

   logic            s1_valid_ff;
   req_payload_type s1_req_ff;
   logic            running_ff, running_in;

   logic [7:0]      idx1, idx2;
   logic            idx1_ok, idx2_ok, dst_ok, addr_ok;
   logic [31:0]     rf1_rdata, rf2_rdata;
   logic [31:0]     src1, src2;

   logic [1:0]      x_status;
   logic            x_redirect;
   logic [7:0]      x_target;
   logic            x_we;
   logic [31:0]     x_wdata;
   logic            x_load;
   logic            store_en;

   logic            s2_valid_ff;
   logic [1:0]      s2_status_ff;
   logic            s2_redirect_ff;
   logic [7:0]      s2_target_ff;
   logic            s2_we_ff;
   logic [7:0]      s2_idx_ff;
   logic [31:0]     s2_wdata_ff;
   logic            s2_load_ff;
   logic [31:0]     s2_result;

   logic            wb_valid_ff;
   logic [7:0]      wb_idx_ff;
   logic [31:0]     wb_data_ff;

   logic            rf_we;
   logic [RW-1:0]   rf_waddr;
   logic [31:0]     rf_wdata;

   logic            dm_we;
   logic [MW-1:0]   dm_waddr;
   logic [7:0]      dm_wdata;
   logic [MW-1:0]   dm_raddr;
   logic [7:0]      dm_rdata;

   rsp_payload_type fifo_ff [2];
   logic            fifo_wr_ptr_ff;
   logic            fifo_rd_ptr_ff;
   logic [1:0]      fifo_cnt_ff, fifo_cnt_in;
   logic            rsp_push, rsp_pop;

   // ---------------------------------------------------------------
   // Mode sequencer: clearing pass after reset, then run
   // ---------------------------------------------------------------
   always_comb begin
      mode_in = mode_ff;
      unique case (mode_ff)
         MODE_CLEAR: begin
            if (clr_cnt_ff == CLR_LAST) begin
               mode_in = MODE_RUN;
            end
         end
         MODE_RUN: mode_in = MODE_RUN;
      endcase
   end

   always_comb begin
      clearing = 1'b0;
      unique case (mode_ff)
         MODE_CLEAR: clearing = 1'b1;
         MODE_RUN:   clearing = 1'b0;
      endcase
   end

   assign clr_cnt_in = clearing ? clr_cnt_ff + MW'(1) : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         mode_ff    <= mode_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // ---------------------------------------------------------------
   // Accept: not clearing, execute stage empty and room reserved in the output queue
   // ---------------------------------------------------------------
   assign fifo_room     = (fifo_cnt_ff == 2'd0) || (fifo_cnt_ff == 2'd1 && !s2_valid_ff);
   assign req_bus.ready = !clearing && !s1_valid_ff && fifo_room;
   assign req_fire      = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_fire;
      end
      if (req_fire) begin
         s1_req_ff <= req_bus.payload;
      end
   end

   // ---------------------------------------------------------------
   // Register file: two copies so both operands read in the same cycle
   // ---------------------------------------------------------------
   bvm_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf1 (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_addr (src1_index(req_bus.payload) >> 0 == 8'd0 ? RW'(0) :
                RW'(src1_index(req_bus.payload))),
      .rd_data (rf1_rdata)
   );

   bvm_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf2 (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_addr (RW'(src2_index(req_bus.payload))),
      .rd_data (rf2_rdata)
   );

   // ---------------------------------------------------------------
   // Execute: operand select with forwarding, ALU, memory access
   // ---------------------------------------------------------------
   assign idx1    = src1_index(s1_req_ff);
   assign idx2    = src2_index(s1_req_ff);
   assign idx1_ok = {1'b0, idx1} < REG_LIMIT;
   assign idx2_ok = {1'b0, idx2} < REG_LIMIT;
   assign dst_ok  = {1'b0, s1_req_ff.op_a} < REG_LIMIT;

   // A writeback on the read edge is missed by the RAM; take it from wb_*
   assign src1 = !idx1_ok ? '0 :
                 (wb_valid_ff && wb_idx_ff == idx1) ? wb_data_ff : rf1_rdata;
   assign src2 = !idx2_ok ? '0 :
                 (wb_valid_ff && wb_idx_ff == idx2) ? wb_data_ff : rf2_rdata;

   assign addr_ok = src1 < MEM_LIMIT;

   always_comb begin
      running_in = running_ff;
      x_status   = STAT_OK;
      x_redirect = 1'b0;
      x_target   = 8'd0;
      x_we       = 1'b0;
      x_wdata    = src1;
      x_load     = 1'b0;
      store_en   = 1'b0;
      if (s1_valid_ff) begin
         if (!running_ff) begin
            x_status = STAT_HALT;
         end else begin
            unique case (s1_req_ff.cmd)
               OP_HALT: begin
                  running_in = 1'b0;
                  x_status   = STAT_HALT;
               end
               OP_LOAD: begin
                  if (!addr_ok) begin
                     running_in = 1'b0;
                     x_status   = STAT_ADDR;
                  end else begin
                     x_we   = dst_ok;
                     x_load = 1'b1;
                  end
               end
               OP_STORE: begin
                  if (!addr_ok) begin
                     running_in = 1'b0;
                     x_status   = STAT_ADDR;
                  end else begin
                     store_en = 1'b1;
                  end
               end
               OP_MOVE: begin
                  x_we    = dst_ok;
                  x_wdata = src1;
               end
               OP_LDI: begin
                  x_we    = dst_ok;
                  x_wdata = 32'(s1_req_ff.op_b);
               end
               OP_ADD: begin
                  x_we    = dst_ok;
                  x_wdata = src1 + src2;
               end
               OP_SUB: begin
                  x_we    = dst_ok;
                  x_wdata = src1 - src2;
               end
               OP_GT: begin
                  x_we    = dst_ok;
                  x_wdata = 32'(src1 > src2);
               end
               OP_GE: begin
                  x_we    = dst_ok;
                  x_wdata = 32'(src1 >= src2);
               end
               OP_EQ: begin
                  x_we    = dst_ok;
                  x_wdata = 32'(src1 == src2);
               end
               OP_ITE: begin
                  x_redirect = 1'b1;
                  x_target   = (src1 != 32'd0) ? s1_req_ff.op_b : s1_req_ff.op_c;
               end
               OP_JUMP: begin
                  x_redirect = 1'b1;
                  x_target   = s1_req_ff.op_a;
               end
               default: begin
                  running_in = 1'b0;
                  x_status   = STAT_ILLEGAL;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b1;
      end else begin
         running_ff <= running_in;
      end
   end

   // ---------------------------------------------------------------
   // Data memory: cleared after reset; store writes in execute, load data returns in writeback
   // ---------------------------------------------------------------
   assign dm_we    = clearing || store_en;
   assign dm_waddr = clearing ? clr_cnt_ff : src1[MW-1:0];
   assign dm_wdata = clearing ? 8'd0 : src2[7:0];
   assign dm_raddr = src1[MW-1:0];

   bvm_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_dmem (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_waddr),
      .wr_data (dm_wdata),
      .rd_addr (dm_raddr),
      .rd_data (dm_rdata)
   );

   // ---------------------------------------------------------------
   // Writeback stage
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         wb_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
         wb_valid_ff <= s2_valid_ff && s2_we_ff;
      end
      if (s1_valid_ff) begin
         s2_status_ff   <= x_status;
         s2_redirect_ff <= x_redirect;
         s2_target_ff   <= x_target;
         s2_we_ff       <= x_we;
         s2_idx_ff      <= s1_req_ff.op_a;
         s2_wdata_ff    <= x_wdata;
         s2_load_ff     <= x_load;
      end
      wb_idx_ff  <= s2_idx_ff;
      wb_data_ff <= s2_result;
   end

   assign s2_result = s2_load_ff ? 32'(dm_rdata) : s2_wdata_ff;

   // Register file write: clearing pass or writeback
   assign rf_we    = clearing ? ({1'b0, clr_cnt_ff} < CLR_REG_LIMIT) : (s2_valid_ff && s2_we_ff);
   assign rf_waddr = clearing ? clr_cnt_ff[RW-1:0] : s2_idx_ff[RW-1:0];
   assign rf_wdata = clearing ? 32'd0 : s2_result;

   // ---------------------------------------------------------------
   // Output queue: two entries, decouples result beats from execution
   // ---------------------------------------------------------------
   assign rsp_push = s2_valid_ff;
   assign rsp_pop  = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      case ({rsp_push, rsp_pop})
         2'b10:   fifo_cnt_in = fifo_cnt_ff + 2'd1;
         2'b01:   fifo_cnt_in = fifo_cnt_ff - 2'd1;
         default: fifo_cnt_in = fifo_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_cnt_ff    <= 2'd0;
         fifo_wr_ptr_ff <= 1'b0;
         fifo_rd_ptr_ff <= 1'b0;
      end else begin
         fifo_cnt_ff <= fifo_cnt_in;
         if (rsp_push) begin
            fifo_wr_ptr_ff <= !fifo_wr_ptr_ff;
         end
         if (rsp_pop) begin
            fifo_rd_ptr_ff <= !fifo_rd_ptr_ff;
         end
      end
      if (rsp_push) begin
         fifo_ff[fifo_wr_ptr_ff] <= '{status:          s2_status_ff,
                                      redirect:        s2_redirect_ff,
                                      redirect_target: s2_target_ff};
      end
   end

   assign rsp_bus.valid   = fifo_cnt_ff != 2'd0;
   assign rsp_bus.payload = fifo_ff[fifo_rd_ptr_ff];

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   `BVM_ASSERT_SAME(a_exec_alone, s1_valid_ff, !s2_valid_ff, "execute overlaps writeback")
   `BVM_ASSERT_NEXT(a_exec_advances, s1_valid_ff, s2_valid_ff, "execute beat lost")
   `BVM_ASSERT_NEXT(a_stop_sticks, !running_ff, !running_ff, "stopped unit restarted")
   `BVM_ASSERT_SAME(a_queue_room, s2_valid_ff && fifo_cnt_ff == 2'd2, rsp_pop,
      "output queue overflow")

endmodule
